FILE: rtl/gdad_pkg.sv
package gdad_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ORD,
    ST_BIG,
    ST_YEAR,
    ST_MONTH,
    ST_OUT
  } gdad_state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic ord_step;
    logic big_step;
    logic year_step;
    logic month_step;
    logic out_load;
  } gdad_cmd_t;

  typedef struct packed {
    logic mod_last;
    logic ord_ovf;
    logic big_gt;
    logic year_gt;
    logic month_done;
  } gdad_sts_t;

  localparam logic [17:0] DAYS_PER_400Y = 18'd146097;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [8:0]  YEAR_CYCLE    = 9'd400;
  localparam logic [8:0]  CYCLE_LAST    = 9'd399;
  localparam logic [2:0]  MOD_STEPS_TOP = 3'd1;
  // ceil(2^17 / 25): exact quotient by 25 for any 12-bit dividend
  localparam logic [12:0] RECIP_25      = 13'd5243;
  localparam logic [3:0]  MONTH_FEB     = 4'd1;
  localparam logic [3:0]  MONTH_MAR     = 4'd2;
  localparam logic [3:0]  MONTH_NOV     = 4'd10;
  localparam logic [3:0]  MONTH_DEC     = 4'd11;

  // Leap rule on the year taken modulo 400.
  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  // Index 0 is January.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    unique case (m)
      4'd0:    days_before = 9'd0;
      4'd1:    days_before = 9'd31;
      4'd2:    days_before = 9'd59;
      4'd3:    days_before = 9'd90;
      4'd4:    days_before = 9'd120;
      4'd5:    days_before = 9'd151;
      4'd6:    days_before = 9'd181;
      4'd7:    days_before = 9'd212;
      4'd8:    days_before = 9'd243;
      4'd9:    days_before = 9'd273;
      4'd10:   days_before = 9'd304;
      4'd11:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

  function automatic logic [8:0] month_len(input logic [3:0] m);
    unique case (m)
      4'd1:                       month_len = 9'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    month_len = 9'd30;
      default:                    month_len = 9'd31;
    endcase
  endfunction

endpackage

FILE: rtl/gregorian_date_add_days_unit.sv
// From input transfer to out_valid the unit reduces the start year modulo 400, adds the start
// date's ordinal day, skips whole 400-year cycles (one per cycle), then single years, when the
// sum runs past the start year, steps through the months and loads the result. A stalled
// output delays the load.
// Throughput: one item at a time; the next input is taken the cycle after the result is loaded.
// Reset: synchronous active-low rst_n returns the controller to idle and clears out_valid.
module gregorian_date_add_days_unit
  import gdad_pkg::*;
#(
  parameter int DAY_COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [DAY_COUNT_BITS-1:0] in_days_to_add,
  input  logic [4:0]                in_start_day,
  input  logic [3:0]                in_start_month,
  input  logic [15:0]               in_start_year,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [4:0]                out_end_day,
  output logic [3:0]                out_end_month,
  output logic [16:0]               out_end_year
);

  gdad_cmd_t cmd;
  gdad_sts_t sts;

  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdad_dp #(
    .DAY_COUNT_BITS(DAY_COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .in_days_to_add (in_days_to_add),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .cmd            (cmd),
    .sts            (sts),
    .out_end_day    (out_end_day),
    .out_end_month  (out_end_month),
    .out_end_year   (out_end_year)
  );

endmodule

FILE: rtl/gdad_ctrl.sv
module gdad_ctrl
  import gdad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  gdad_sts_t sts,
  output gdad_cmd_t cmd
);

  gdad_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_ORD;
        end
      end
      ST_ORD: begin
        cmd.ord_step = 1'b1;
        state_nxt    = sts.ord_ovf ? ST_BIG : ST_MONTH;
      end
      ST_BIG: begin
        // skip whole 400-year cycles first
        if (sts.big_gt) begin
          cmd.big_step = 1'b1;
        end else begin
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (sts.year_gt) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // load the output register once it is empty or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/gdad_dp.sv
module gdad_dp
  import gdad_pkg::*;
#(
  parameter int DAY_COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic [DAY_COUNT_BITS-1:0] in_days_to_add,
  input  logic [4:0]                in_start_day,
  input  logic [3:0]                in_start_month,
  input  logic [15:0]               in_start_year,
  input  gdad_cmd_t                 cmd,
  output gdad_sts_t                 sts,
  output logic [4:0]                out_end_day,
  output logic [3:0]                out_end_month,
  output logic [16:0]               out_end_year
);

  localparam int AW = DAY_COUNT_BITS + 1;
  localparam int CW = (AW > 18) ? AW : 18;

  logic [AW-1:0] acc_r;
  logic [16:0]   yr_r;
  logic [15:0]   rem_r;
  logic [7:0]    quo_r;
  logic [2:0]    step_r;
  logic [4:0]    day_r;
  logic [3:0]    mon_r;
  logic [3:0]    mi_r;
  logic [4:0]    end_day_r;
  logic [3:0]    end_month_r;
  logic [16:0]   end_year_r;

  logic [24:0]   quo_prod;
  logic [15:0]   quo_x400;
  logic [8:0]    ymod;
  logic          leap;
  logic [8:0]    ord;
  logic [8:0]    diy;
  logic [AW-1:0] ord_sum;
  logic [8:0]    mlen;
  logic [8:0]    ymod_inc;

  assign ymod     = rem_r[8:0];
  assign leap     = is_leap(ymod);
  assign diy      = DAYS_PER_YEAR + {8'd0, leap};
  assign ymod_inc = (ymod == CYCLE_LAST) ? 9'd0 : ymod + 9'd1;
  // year / 400 = (year / 16) / 25
  assign quo_prod = {13'd0, rem_r[15:4]} * {12'd0, RECIP_25};
  assign quo_x400 = {8'd0, quo_r} * {7'd0, YEAR_CYCLE};
  assign ord      = days_before(mon_r) + {4'd0, day_r}
                    + {8'd0, (leap && (mon_r >= MONTH_MAR))};
  assign ord_sum  = acc_r + AW'(ord);
  assign mlen     = month_len(mi_r) + {8'd0, (leap && (mi_r == MONTH_FEB))};

  assign sts.mod_last   = (step_r == 3'd0);
  assign sts.ord_ovf    = (ord_sum > AW'(diy));
  assign sts.big_gt     = (CW'(acc_r) > CW'(DAYS_PER_400Y));
  assign sts.year_gt    = (acc_r > AW'(diy));
  assign sts.month_done = (acc_r <= AW'(mlen)) || (mi_r == MONTH_NOV);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r  <= AW'(in_days_to_add);
      yr_r   <= {1'b0, in_start_year};
      rem_r  <= in_start_year;
      step_r <= MOD_STEPS_TOP;
      day_r  <= (in_start_day == 5'd0) ? 5'd1 : in_start_day;
      if (in_start_month == 4'd0) begin
        mon_r <= 4'd0;
      end else if (in_start_month > 4'd12) begin
        mon_r <= MONTH_DEC;
      end else begin
        mon_r <= in_start_month - 4'd1;
      end
    end
    if (cmd.mod_step) begin
      // reduce the start year modulo 400: quotient first, then subtract
      if (step_r == MOD_STEPS_TOP) begin
        quo_r <= quo_prod[24:17];
      end else begin
        rem_r <= rem_r - quo_x400;
      end
      step_r <= step_r - 3'd1;
    end
    if (cmd.ord_step) begin
      mi_r <= 4'd0;
      if (sts.ord_ovf) begin
        acc_r <= ord_sum - AW'(diy);
        yr_r  <= yr_r + 17'd1;
        rem_r <= {7'd0, ymod_inc};
      end else begin
        acc_r <= ord_sum;
      end
    end
    if (cmd.big_step) begin
      acc_r <= AW'(CW'(acc_r) - CW'(DAYS_PER_400Y));
      yr_r  <= yr_r + 17'(YEAR_CYCLE);
    end
    if (cmd.year_step) begin
      acc_r <= acc_r - AW'(diy);
      yr_r  <= yr_r + 17'd1;
      rem_r <= {7'd0, ymod_inc};
    end
    if (cmd.month_step && (acc_r > AW'(mlen))) begin
      acc_r <= acc_r - AW'(mlen);
      mi_r  <= mi_r + 4'd1;
    end
    if (cmd.out_load) begin
      end_day_r   <= acc_r[4:0];
      end_month_r <= mi_r + 4'd1;
      end_year_r  <= yr_r;
    end
  end

  assign out_end_day   = end_day_r;
  assign out_end_month = end_month_r;
  assign out_end_year  = end_year_r;

endmodule

FILE: rtl/gdad_chk.sv
module gdad_chk
  import gdad_pkg::*;
#(
  parameter int DAY_COUNT_BITS = 24
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [DAY_COUNT_BITS-1:0] in_days_to_add,
  input logic [4:0]                in_start_day,
  input logic [3:0]                in_start_month,
  input logic [15:0]               in_start_year,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [4:0]                out_end_day,
  input logic [3:0]                out_end_month,
  input logic [16:0]               out_end_year
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_end_day) && $stable(out_end_month)
                               && $stable(out_end_year))
    else $error("stalled result changed");

  // an accepted item keeps the input side busy until its result is loaded
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !$rose(out_valid))
    else $error("input side not busy after transfer");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_end_day != 5'd0) && (out_end_month != 4'd0)
                  && (out_end_month <= 4'd12))
    else $error("result date out of range");

endmodule

bind gregorian_date_add_days_unit gdad_chk #(
  .DAY_COUNT_BITS(DAY_COUNT_BITS)
) u_gdad_chk (.*);
